### design/assert_macros.svh
// Assertion macros for the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### design/sfcc_pkg.sv
// Types, constants and helper functions for the sequence frame CRC checker.
package sfcc_pkg;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_S,
      PH_E,
      PH_Q,
      PH_DEC,
      PH_HEX,
      PH_HEXD,
      PH_TAIL
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_CORRUPT = 2'd1,
      ST_MISSING = 2'd2,
      ST_ORDER   = 2'd3
   } status_type;

   localparam logic [31:0] NO_PREV  = 32'hFFFF_FFFF;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [7:0]  CH_LF    = 8'h0A;
   localparam logic [7:0]  CH_S     = 8'h53;
   localparam logic [7:0]  CH_E     = 8'h45;
   localparam logic [7:0]  CH_Q     = 8'h51;
   localparam logic [7:0]  CH_COLON = 8'h3A;

   typedef struct packed {
      logic        valid;
      status_type  status;
      logic [31:0] seq_number;
      logic [15:0] received_crc;
      logic [15:0] computed_crc;
      logic [31:0] expected_seq;
      logic [31:0] missed_count;
   } result_type;

   // CRC-16/CCITT-FALSE, one byte, MSB first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   // bit 4 = valid hex digit, bits 3:0 = value
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
      else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
         r = {1'b1, c[3:0] + 4'd9};
      return r;
   endfunction

endpackage

### design/sfcc_if.sv
// Valid/ready channel interfaces for request bytes and check results.
interface sfcc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfcc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] seq_number;
   logic [15:0] received_crc;
   logic [15:0] computed_crc;
   logic [31:0] expected_seq;
   logic [31:0] missed_count;

   modport source (output valid, output status, output seq_number, output received_crc,
                   output computed_crc, output expected_seq, output missed_count,
                   input ready);
   modport sink   (input valid, input status, input seq_number, input received_crc,
                   input computed_crc, input expected_seq, input missed_count,
                   output ready);
endinterface

### design/sfcc_parser.sv
// Line parser: per-byte state update, CRC, accumulators and line classification.
module sfcc_parser import sfcc_pkg::*; #(
   parameter int MAX_SEQ_DIGITS = 10
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] rx_byte,
   output result_type result
);

   localparam int DW = $clog2(MAX_SEQ_DIGITS + 1);

   phase_type   phase_ff, phase_in;
   logic        bad_ff, bad_in;
   logic [15:0] crc_ff, crc_in;
   logic [31:0] seq_ff, seq_in;
   logic [DW-1:0] cnt_ff, cnt_in;
   logic [15:0] hex_ff, hex_in;
   logic [31:0] prev_ff, prev_in;
   logic [31:0] exp_ff, exp_in;

   logic        lf, blank, hex_ok, dec_ok, crc_take, line_done;
   logic [4:0]  hv;
   logic [35:0] prod;

   assign lf     = (rx_byte == CH_LF);
   assign blank  = is_blank(rx_byte);
   assign hv     = hex_value(rx_byte);
   assign hex_ok = hv[4];
   // seq * 10 + digit
   assign prod   = ({4'd0, seq_ff} << 3) + ({4'd0, seq_ff} << 1) + {32'd0, rx_byte[3:0]};
   assign dec_ok = is_digit(rx_byte) && (cnt_ff < DW'(MAX_SEQ_DIGITS))
                   && !((cnt_ff == DW'(1)) && (seq_ff == 32'd0))
                   && (prod[35:32] == 4'd0);
   assign crc_take = ((phase_ff == PH_IDLE) && (rx_byte == CH_S))
                  || ((phase_ff == PH_S) && (rx_byte == CH_E))
                  || ((phase_ff == PH_E) && (rx_byte == CH_Q))
                  || ((phase_ff == PH_Q) && (rx_byte == CH_COLON))
                  || ((phase_ff == PH_DEC) && dec_ok);
   assign line_done = step && lf && !bad_ff && ((phase_ff == PH_HEXD) || (phase_ff == PH_TAIL));

   // next phase and bad-line flag
   always_comb begin
      phase_in = phase_ff;
      bad_in   = bad_ff;
      if (step) begin
         if (lf) begin
            phase_in = PH_IDLE;
            bad_in   = 1'b0;
         end else if (!bad_ff) begin
            unique case (phase_ff)
               PH_IDLE: begin
                  if (rx_byte == CH_S) phase_in = PH_S;
                  else if (!blank)     bad_in   = 1'b1;
               end
               PH_S: begin
                  if (rx_byte == CH_E) phase_in = PH_E;
                  else                 bad_in   = 1'b1;
               end
               PH_E: begin
                  if (rx_byte == CH_Q) phase_in = PH_Q;
                  else                 bad_in   = 1'b1;
               end
               PH_Q: begin
                  if (rx_byte == CH_COLON) phase_in = PH_DEC;
                  else                     bad_in   = 1'b1;
               end
               PH_DEC: begin
                  if (dec_ok) phase_in = PH_DEC;
                  else if ((rx_byte == CH_COLON) && (cnt_ff != '0)) phase_in = PH_HEX;
                  else bad_in = 1'b1;
               end
               PH_HEX: begin
                  if (hex_ok) phase_in = PH_HEXD;
                  else        bad_in   = 1'b1;
               end
               PH_HEXD: begin
                  if (hex_ok)     phase_in = PH_HEXD;
                  else if (blank) phase_in = PH_TAIL;
                  else            bad_in   = 1'b1;
               end
               PH_TAIL: begin
                  if (!blank) bad_in = 1'b1;
               end
            endcase
         end
      end
   end

   // accumulators and previous sequence number
   always_comb begin
      crc_in  = crc_ff;
      seq_in  = seq_ff;
      cnt_in  = cnt_ff;
      hex_in  = hex_ff;
      prev_in = prev_ff;
      exp_in  = exp_ff;
      if (step) begin
         if (lf) begin
            crc_in = CRC_INIT;
            seq_in = 32'd0;
            cnt_in = '0;
            hex_in = 16'd0;
            if (line_done) begin
               prev_in = seq_ff;
               exp_in  = seq_ff + 32'd1;
            end
         end else if (!bad_ff) begin
            if (crc_take) crc_in = crc_byte(crc_ff, rx_byte);
            if ((phase_ff == PH_DEC) && dec_ok) begin
               seq_in = prod[31:0];
               cnt_in = cnt_ff + DW'(1);
            end
            if (((phase_ff == PH_HEX) || (phase_ff == PH_HEXD)) && hex_ok)
               hex_in = {hex_ff[11:0], hv[3:0]};
         end
      end
   end

   // classification of a finished line
   always_comb begin
      result.valid        = line_done;
      result.seq_number   = seq_ff;
      result.received_crc = hex_ff;
      result.computed_crc = crc_ff;
      result.expected_seq = exp_ff;
      result.missed_count = 32'd0;
      if (crc_ff != hex_ff) begin
         result.status = ST_CORRUPT;
      end else if ((prev_ff != NO_PREV) && (seq_ff != exp_ff)) begin
         if (seq_ff > exp_ff) begin
            result.status       = ST_MISSING;
            result.missed_count = seq_ff - exp_ff;
         end else begin
            result.status = ST_ORDER;
         end
      end else begin
         result.status = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         bad_ff   <= 1'b0;
         crc_ff   <= CRC_INIT;
         seq_ff   <= 32'd0;
         cnt_ff   <= '0;
         hex_ff   <= 16'd0;
         prev_ff  <= NO_PREV;
         exp_ff   <= 32'd0;
      end else begin
         phase_ff <= phase_in;
         bad_ff   <= bad_in;
         crc_ff   <= crc_in;
         seq_ff   <= seq_in;
         cnt_ff   <= cnt_in;
         hex_ff   <= hex_in;
         prev_ff  <= prev_in;
         exp_ff   <= exp_in;
      end
   end

endmodule

### design/seq_frame_crc_checker_top.sv
// Top level of the sequence frame CRC checker: byte input stage, parser, result register.
//
// Usage:
//   req_ch carries one received UART character per word (rx_byte). Lines of the
//   form "SEQ:<decimal>:<hex>" ended by 0x0A are parsed; blanks around the line
//   are skipped. Each well-formed line yields one word on rsp_ch with status
//   (ok / corrupt / missing / out of order), the parsed number, received and
//   computed CRC-16/CCITT-FALSE, the expected number and the gap count.
//   Malformed, blank or empty lines produce no word.
// Path: a newline word accepted on req_ch passes the input register, then the
//   result register, before its result is valid on rsp_ch.
// Throughput: one word per cycle while rsp_ch does not hold the result register;
//   the per-byte CRC and decimal accumulate fit between the input register and the parser state.
// Reset (synchronous, active high): parser goes idle, CRC to 0xFFFF, no
//   previous sequence number, both pipeline valids cleared.
// Stall: when rsp_ch is held, the result register keeps its word and the
//   input register can still fill, so one more byte is taken before req_ch
//   ready drops.
`include "assert_macros.svh"

module seq_frame_crc_checker_top import sfcc_pkg::*; #(
   parameter int MAX_SEQ_DIGITS = 10
) (
   input  logic        clock,
   input  logic        reset,
   sfcc_req_if.sink    req_ch,
   sfcc_rsp_if.source  rsp_ch
);

   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff, s1_byte_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   result_type res;
   logic       adv, step;

   // pipeline moves when the result register is empty or being drained
   assign adv  = !out_valid_ff || rsp_ch.ready;
   assign step = s1_valid_ff && adv;
   assign req_ch.ready = !s1_valid_ff || adv;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      if (req_ch.ready) begin
         s1_valid_in = req_ch.valid;
         if (req_ch.valid) s1_byte_in = req_ch.rx_byte;
      end
   end

   sfcc_parser #(
      .MAX_SEQ_DIGITS(MAX_SEQ_DIGITS)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (s1_byte_ff),
      .result  (res)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (adv) begin
         out_valid_in = res.valid;
         if (res.valid) out_in = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      s1_byte_ff <= s1_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.status       = out_ff.status;
   assign rsp_ch.seq_number   = out_ff.seq_number;
   assign rsp_ch.received_crc = out_ff.received_crc;
   assign rsp_ch.computed_crc = out_ff.computed_crc;
   assign rsp_ch.expected_seq = out_ff.expected_seq;
   assign rsp_ch.missed_count = out_ff.missed_count;

   // a gap count appears exactly with the missing status
   `ASSERT_IMPLIES(a_missed_nonzero, clock, reset, out_valid_ff && (out_ff.status == ST_MISSING), out_ff.missed_count != 32'd0)
   `ASSERT_IMPLIES(a_missed_zero, clock, reset, out_valid_ff && (out_ff.status != ST_MISSING), out_ff.missed_count == 32'd0)
   // ok, missing and order statuses only with a matching checksum
   `ASSERT_IMPLIES(a_crc_match, clock, reset, out_valid_ff && (out_ff.status != ST_CORRUPT), out_ff.computed_crc == out_ff.received_crc)
   // a stalled result is not dropped
   `ASSERT_NEXT(a_hold_result, clock, reset, out_valid_ff && !rsp_ch.ready, out_valid_ff)

endmodule

### tb/sv/sfcc_tb_pkg.sv
// Line-check predictor and result scoreboard for the sequence frame CRC checker bench.
`timescale 1ns / 1ps
package sfcc_tb_pkg;
   import sfcc_pkg::*;

   localparam int unsigned SEQ_DIGIT_LIMIT = 10;
   localparam int unsigned REPORT_LIMIT    = 10;

   typedef struct packed {
      status_type  status;
      logic [31:0] seq_number;
      logic [15:0] received_crc;
      logic [15:0] computed_crc;
      logic [31:0] expected_seq;
      logic [31:0] missed_count;
   } line_verdict_t;

   // bit-serial CRC-16/CCITT-FALSE update, MSB first
   function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] r;
      logic        fb;
      r = crc;
      for (int k = 7; k >= 0; k--) begin
         fb = r[15] ^ b[k];
         r  = {r[14:0], 1'b0};
         if (fb) r = r ^ CRC_POLY;
      end
      return r;
   endfunction

   function automatic bit is_ws(input logic [7:0] c);
      return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C || c == 8'h0D;
   endfunction

   // {hit, value}
   function automatic logic [4:0] nibble_of(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return {1'b1, c[3:0]};
      if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h37)};
      if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h57)};
      return 5'd0;
   endfunction

   class line_verdict_board;
      phase_type     phase;
      logic [15:0]   crc;
      logic [39:0]   seq_acc;
      int unsigned   ndig;
      logic [15:0]   hex_acc;
      bit            bad;
      logic [31:0]   last_seq;
      line_verdict_t verdict_q[$];
      int unsigned   failures;
      int unsigned   reported;

      function new();
         start_line();
         last_seq = NO_PREV;
         failures = 0;
         reported = 0;
      endfunction

      function void start_line();
         phase   = PH_IDLE;
         crc     = CRC_INIT;
         seq_acc = '0;
         ndig    = 0;
         hex_acc = '0;
         bad     = 1'b0;
      endfunction

      function void parse_char(input logic [7:0] c);
         logic [4:0] h;
         bit         ok;
         if (bad) return;
         h  = nibble_of(c);
         ok = 1'b0;
         case (phase)
            PH_IDLE: begin
               if (is_ws(c)) ok = 1'b1;
               else if (c == CH_S) begin
                  crc = crc16_step(crc, c); phase = PH_S; ok = 1'b1;
               end
            end
            PH_S: if (c == CH_E) begin
               crc = crc16_step(crc, c); phase = PH_E; ok = 1'b1;
            end
            PH_E: if (c == CH_Q) begin
               crc = crc16_step(crc, c); phase = PH_Q; ok = 1'b1;
            end
            PH_Q: if (c == CH_COLON) begin
               crc = crc16_step(crc, c); phase = PH_DEC; ok = 1'b1;
            end
            PH_DEC: begin
               if (c >= 8'h30 && c <= 8'h39) begin
                  // leading zero and digit overflow both kill the line
                  if (ndig < SEQ_DIGIT_LIMIT && !(ndig == 1 && seq_acc == 0)) begin
                     seq_acc = seq_acc * 40'd10 + 40'(c - 8'h30);
                     if (seq_acc <= 40'hFF_FFFF_FFFF >> 8) begin
                        ndig++;
                        crc = crc16_step(crc, c);
                        ok  = 1'b1;
                     end
                  end
               end else if (c == CH_COLON && ndig > 0) begin
                  phase = PH_HEX; ok = 1'b1;
               end
            end
            PH_HEX, PH_HEXD: begin
               if (h[4]) begin
                  hex_acc = {hex_acc[11:0], h[3:0]};
                  phase   = PH_HEXD;
                  ok      = 1'b1;
               end else if (phase == PH_HEXD && is_ws(c)) begin
                  phase = PH_TAIL; ok = 1'b1;
               end
            end
            PH_TAIL: ok = is_ws(c);
            default: ok = 1'b0;
         endcase
         if (!ok) bad = 1'b1;
      endfunction

      // one accepted input word; a newline closing a good line queues a verdict
      function void take_rx_byte(input logic [7:0] c);
         line_verdict_t v;
         if (c != CH_LF) begin
            parse_char(c);
            return;
         end
         if (!bad && (phase == PH_HEXD || phase == PH_TAIL)) begin
            v.seq_number   = seq_acc[31:0];
            v.expected_seq = last_seq + 32'd1;
            v.received_crc = hex_acc;
            v.computed_crc = crc;
            v.missed_count = '0;
            if (crc != hex_acc) v.status = ST_CORRUPT;
            else if (last_seq != NO_PREV && v.seq_number != v.expected_seq) begin
               if (v.seq_number > v.expected_seq) begin
                  v.status       = ST_MISSING;
                  v.missed_count = v.seq_number - v.expected_seq;
               end else v.status = ST_ORDER;
            end else v.status = ST_OK;
            verdict_q.push_back(v);
            last_seq = v.seq_number;
         end
         start_line();
      endfunction

      function void match_verdict(input line_verdict_t got);
         line_verdict_t want;
         if (verdict_q.size() == 0) begin
            failures++;
            if (reported < REPORT_LIMIT) begin
               reported++;
               $display("unexpected result: status %0d seq %0d", got.status, got.seq_number);
            end
            return;
         end
         want = verdict_q.pop_front();
         if (got.status !== want.status || got.seq_number !== want.seq_number ||
             got.received_crc !== want.received_crc ||
             got.computed_crc !== want.computed_crc ||
             got.expected_seq !== want.expected_seq ||
             got.missed_count !== want.missed_count) begin
            failures++;
            if (reported < REPORT_LIMIT) begin
               reported++;
               $display("mismatch exp: st %0d seq %0d rx %h calc %h next %0d gap %0d",
                        want.status, want.seq_number, want.received_crc,
                        want.computed_crc, want.expected_seq, want.missed_count);
               $display("         got: st %0d seq %0d rx %h calc %h next %0d gap %0d",
                        got.status, got.seq_number, got.received_crc,
                        got.computed_crc, got.expected_seq, got.missed_count);
            end
         end
      endfunction

      function int unsigned pending();
         return verdict_q.size();
      endfunction
   endclass

endpackage

### tb/sv/tb_top.sv
// Top-level bench for the sequence frame CRC checker: clock, reset, stimulus and checking.
`timescale 1ns / 1ps
module tb_top;
   import sfcc_pkg::*;
   import sfcc_tb_pkg::*;

   localparam int unsigned WORD_TARGET  = 1850;  // input words, directed part included
   localparam int unsigned IDLE_LIMIT   = 1000;  // cycles with no handshake on either side
   localparam int unsigned DRAIN_CYCLES = 8;     // result register path is two deep

   localparam logic [7:0] BLANKS [5] = '{8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D};

   typedef enum {RX_FREE, RX_RANDOM, RX_PERIODIC, RX_LONG} rx_mode_t;
   typedef enum {LN_FRAME, LN_BROKEN, LN_NOISE, LN_BLANK} line_kind_t;
   typedef enum {BR_SWAP, BR_BLANK, BR_CUT, BR_ZERO, BR_BIG} break_kind_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sfcc_req_if req_ch ();
   sfcc_rsp_if rsp_ch ();

   seq_frame_crc_checker_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #2 clock = ~clock;

   line_verdict_board board = new;

   logic [7:0]  line_buf[$];     // bytes of the line being built
   int unsigned words_sent  = 0;
   int unsigned burst_left  = 10;
   int unsigned idle_cycles = 0;
   logic [31:0] gen_last    = '0; // last number the generator put in a frame

   // ---------------------------------------------------------------------
   // Sender: one word per call, driven at the falling edge. After each
   // accepted word the burst counter decides whether valid drops for a gap.
   // Within a word, valid is only lowered here, so it never sees two assignments per step.
   // ---------------------------------------------------------------------
   task automatic send_word(input logic [7:0] b);
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
      board.take_rx_byte(b);
      words_sent++;
      @(negedge clock);
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         // now and then a long run with no gaps at all
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                   : $urandom_range(1, 20);
      end else begin
         burst_left--;
      end
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endtask

   task automatic put_blanks(input int unsigned n);
      repeat (n) line_buf.push_back(BLANKS[$urandom_range(0, 4)]);
   endtask

   // "SEQ:<dec>:<hex>" with the hex field set to the true CRC xor flip;
   // extra random hex digits go in front and shift out in the block
   task automatic put_frame(input logic [31:0] seq, input logic [15:0] flip,
                            input int unsigned extra, input bit upper);
      string       dec;
      string       hx;
      logic [15:0] c;
      dec = $sformatf("SEQ:%0d", seq);
      c   = CRC_INIT;
      for (int i = 0; i < dec.len(); i++) c = crc16_step(c, dec[i]);
      hx = "";
      repeat (extra) hx = {hx, $sformatf("%h", 4'($urandom_range(0, 15)))};
      hx = {hx, $sformatf("%h", c ^ flip)};
      if (upper) hx = hx.toupper();
      put_text({dec, ":", hx});
   endtask

   // newline closes the line, then the whole buffer goes out
   task automatic end_line();
      line_buf.push_back(CH_LF);
      foreach (line_buf[i]) send_word(line_buf[i]);
      line_buf.delete();
   endtask

   function automatic logic [31:0] next_seq_pick();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return gen_last + 32'd1;
         6:       return gen_last + $urandom_range(2, 50);
         7:       return gen_last - $urandom_range(0, 20);
         8:       return $urandom;
         default: return NO_PREV - $urandom_range(0, 3);  // near the wrap
      endcase
   endfunction

   task automatic put_random_frame();
      logic [31:0] s;
      s = next_seq_pick();
      put_blanks($urandom_range(0, 2));
      put_frame(s, ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535)) : 16'h0,
                ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0,
                $urandom_range(0, 1));
      put_blanks($urandom_range(0, 2));
      gen_last = s;
   endtask

   // ---------------------------------------------------------------------
   // Receiver: ready changes at the falling edge; at regular points the stall
   // pattern is drawn anew from free flow, random, periodic and long stalls.
   // ---------------------------------------------------------------------
   initial begin : rsp_stall
      int unsigned cyc;
      rx_mode_t    mode;
      rsp_ch.ready = 1'b0;
      cyc  = 0;
      mode = RX_FREE;
      forever begin
         @(negedge clock);
         if (cyc % 96 == 0) mode = rx_mode_t'($urandom_range(0, 3));
         case (mode)
            RX_FREE:     rsp_ch.ready <= 1'b1;
            RX_RANDOM:   rsp_ch.ready <= ($urandom_range(0, 9) < 7);
            RX_PERIODIC: rsp_ch.ready <= (cyc % 4 != 3);
            default:     rsp_ch.ready <= (cyc % 16 < 6);   // long stalls
         endcase
         cyc++;
      end
   end

   // ---------------------------------------------------------------------
   // Result check and watchdog, both on the rising edge. The watchdog fails
   // the run when neither channel moves a word and its idle count has reached IDLE_LIMIT.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : rsp_monitor
      line_verdict_t seen;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.status       = status_type'(rsp_ch.status);
            seen.seq_number   = rsp_ch.seq_number;
            seen.received_crc = rsp_ch.received_crc;
            seen.computed_crc = rsp_ch.computed_crc;
            seen.expected_seq = rsp_ch.expected_seq;
            seen.missed_count = rsp_ch.missed_count;
            board.match_verdict(seen);
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      line_kind_t  kind;
      break_kind_t brk;
      int unsigned pick;
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed lines ---
      end_line();                                            // empty line
      line_buf = '{8'h20, 8'h09, 8'h0D, 8'h0B, 8'h0C};
      end_line();                                            // blanks only
      put_text("  "); put_frame(32'd0, 16'h0, 0, 1'b0); line_buf.push_back(8'h0D);
      end_line();                                            // first line, no previous: ok
      put_frame(32'd1, 16'h0, 0, 1'b0); end_line();          // in order
      put_frame(32'd5, 16'h0, 2, 1'b0); end_line();          // gap of three, long hex
      put_frame(32'd3, 16'h0, 0, 1'b1); end_line();          // out of order
      put_frame(32'd4, 16'h0001, 0, 1'b0); end_line();       // checksum corrupt
      put_text("SEQ:01:ffff"); end_line();                   // leading zero
      put_text("SEQ:4294967296:ffff"); end_line();           // above 32 bits
      put_text("SEQ:12345678901:ffff"); end_line();          // too many digits
      put_frame(32'hFFFF_FFFE, 16'h0, 0, 1'b0); end_line();  // large gap
      put_frame(32'hFFFF_FFFF, 16'h0, 0, 1'b1); end_line();  // max value, leaves no previous
      put_frame(32'd7, 16'h0, 0, 1'b0); end_line();          // ok since nothing before
      put_text("SEQ: 8:ffff"); end_line();                   // blank inside
      put_text("SEQ:8:"); end_line();                        // empty hex field
      put_text("SEQ:8"); end_line();                         // no second colon
      put_text("xSEQ:8:abcd"); end_line();                   // junk in front
      put_text("SEQ:8:12 34"); end_line();                   // blank inside hex
      put_text("SEQ:8:1g"); end_line();                      // bad hex digit
      put_text("seq:8:1234"); end_line();                    // wrong case tag
      line_buf = '{8'hFF, 8'h80, 8'h00, 8'h53};
      end_line();                                            // high-bit noise
      put_text("SEQ:8:7"); end_line();                       // one hex digit
      put_frame(32'd9, 16'h0, 4, 1'b1); put_text("  ");
      line_buf.push_back(8'h09); end_line();                 // eight hex digits, tail blanks
      gen_last = 32'd9;

      // --- random lines: mostly good frames, some broken ones, noise and blank lines ---
      while (words_sent < WORD_TARGET) begin
         pick = $urandom_range(0, 99);
         kind = (pick < 65) ? LN_FRAME : (pick < 85) ? LN_BROKEN :
                (pick < 95) ? LN_NOISE : LN_BLANK;
         case (kind)
            LN_FRAME: put_random_frame();
            LN_BROKEN: begin
               put_random_frame();
               brk = break_kind_t'($urandom_range(0, 4));
               case (brk)
                  BR_SWAP:
                     line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom);
                  BR_BLANK:
                     line_buf.insert($urandom_range(1, line_buf.size() - 1),
                                     BLANKS[$urandom_range(0, 4)]);
                  BR_CUT:
                     repeat ($urandom_range(1, line_buf.size() - 1)) void'(line_buf.pop_back());
                  BR_ZERO: begin
                     line_buf.delete();
                     put_text($sformatf("SEQ:0%0d:%h", $urandom_range(0, 999),
                                        16'($urandom)));
                  end
                  default: begin
                     line_buf.delete();
                     put_text($sformatf("SEQ:%0d:%h", 64'h1_0000_0000 + 64'($urandom),
                                        16'($urandom)));
                  end
               endcase
            end
            LN_NOISE: repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom));
            default: put_blanks($urandom_range(0, 3));
         endcase
         end_line();
      end
      req_ch.valid <= 1'b0;

      // drain: every queued verdict must come back, then a short quiet window
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.failures == 0 && board.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### files.f
+incdir+design
design/sfcc_pkg.sv
design/sfcc_if.sv
design/sfcc_parser.sv
design/seq_frame_crc_checker_top.sv
tb/sv/sfcc_tb_pkg.sv
tb/sv/tb_top.sv
